[rtl/ecbm_pkg.sv]
// Shared types and constants for the clamped-edge box mean block.
`timescale 1ns / 1ps
package ecbm_pkg;

  localparam int ELEV_W    = 24;
  localparam int POS_W     = 10;
  localparam int RAD_REG_W = 4;
  localparam int DIM_REG_W = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_MAX_RADIUS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd2;

  localparam logic [RAD_REG_W-1:0] RADIUS_RESET = 4'd1;
  localparam logic [DIM_REG_W-1:0] DIM_RESET    = 11'd1024;

  typedef struct packed {
    logic take;
    logic start;
    logic back_row;
    logic scan;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic back_done;
    logic scan_last;
    logic div_done;
    logic out_free;
    logic last;
    logic complete;
  } sts_t;

endpackage

[rtl/ecbm_in_if.sv]
// Input channel: grid cells and drain beats.
`timescale 1ns / 1ps
interface ecbm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [ecbm_pkg::ELEV_W-1:0]  elevation;
  modport source (output valid, kind, elevation, input ready);
  modport sink   (input valid, kind, elevation, output ready);
endinterface

[rtl/ecbm_out_if.sv]
// Output channel: smoothed cells.
`timescale 1ns / 1ps
interface ecbm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ecbm_pkg::ELEV_W-1:0] smoothed;
  logic [ecbm_pkg::POS_W-1:0]         out_row;
  logic [ecbm_pkg::POS_W-1:0]         out_col;
  logic                               last_of_grid;
  modport source (output valid, smoothed, out_row, out_col, last_of_grid, input ready);
  modport sink   (input valid, smoothed, out_row, out_col, last_of_grid, output ready);
endinterface

[rtl/ecbm_ctrl.sv]
// Sequencer for the box mean: accept, check, window scan, divide, emit.
`timescale 1ns / 1ps
module ecbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ecbm_pkg::sts_t   sts,
  output ecbm_pkg::cmd_t   cmd
);
  import ecbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_START, S_BACK, S_SCAN, S_WAIT, S_DIVINIT, S_DIV, S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:    cmd.take     = in_valid;
      S_START:   cmd.start    = 1'b1;
      S_BACK:    cmd.back_row = !sts.back_done;
      S_SCAN:    cmd.scan     = 1'b1;
      S_DIVINIT: cmd.div_init = 1'b1;
      S_DIV:     cmd.div_step = !sts.div_done;
      S_FINISH:  cmd.emit     = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:    if (in_valid) state <= S_CHECK;
        S_CHECK:   state <= sts.ready ? S_START : S_IDLE;
        S_START:   state <= S_BACK;
        S_BACK:    if (sts.back_done) state <= S_SCAN;
        S_SCAN:    if (sts.scan_last) state <= S_WAIT;
        S_WAIT:    state <= S_DIVINIT;
        S_DIVINIT: state <= S_DIV;
        S_DIV:     if (sts.div_done) state <= S_FINISH;
        S_FINISH:  if (sts.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/ecbm_dp.sv]
// Datapath: row store, positions, window accumulator, divider, result register.
`timescale 1ns / 1ps
module ecbm_dp #(
  parameter int MAX_COLS   = ecbm_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = ecbm_pkg::DEF_MAX_ROWS,
  parameter int MAX_RADIUS = ecbm_pkg::DEF_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ecbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ecbm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                kind,
  input  logic signed [ecbm_pkg::ELEV_W-1:0]  elevation,
  input  ecbm_pkg::cmd_t                      cmd,
  output ecbm_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ecbm_pkg::ELEV_W-1:0]  smoothed,
  output logic [ecbm_pkg::POS_W-1:0]          out_row,
  output logic [ecbm_pkg::POS_W-1:0]          out_col,
  output logic                                last_of_grid
);
  import ecbm_pkg::*;

  localparam int DEPTH   = (2 * MAX_RADIUS + 1) * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(MAX_COLS + 1);
  localparam int RWW     = $clog2(MAX_ROWS + 1);
  localparam int RDW     = $clog2(MAX_RADIUS + 1);
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNTW    = $clog2(WIN_MAX + 1);
  localparam int SUMW    = ELEV_W + CNTW + 1;
  localparam int NUMW    = SUMW + 1;
  localparam int DENW    = CNTW + 1;
  localparam int DCW     = $clog2(NUMW + 1);
  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  logic [RAD_REG_W-1:0] reg_radius;
  logic [DIM_REG_W-1:0] reg_cols;
  logic [DIM_REG_W-1:0] reg_rows;
  logic [RDW-1:0]       rad;
  logic [CW-1:0]        cols;
  logic [RWW-1:0]       rows;

  logic [RWW-1:0] in_row;
  logic [CW-1:0]  in_col;
  logic [AW-1:0]  in_slot;
  logic           complete;
  logic [RWW-1:0] nxt_row;
  logic [CW-1:0]  nxt_col;
  logic [AW-1:0]  nxt_slot;

  logic [RWW-1:0] w_r0, w_r1, wr_hi, si;
  logic [CW-1:0]  w_c0, w_c1, wc_lo, wc_hi, sj, span;
  logic [RDW-1:0] back_cnt;
  logic [AW-1:0]  ptr;

  logic signed [ELEV_W-1:0] mem [DEPTH];
  logic signed [ELEV_W-1:0] rd_data;
  logic                     rv;
  logic signed [SUMW-1:0]   sum;
  logic [CNTW-1:0]          cnt;

  logic [NUMW-1:0] num, quo;
  logic [DENW:0]   rem;
  logic [DENW-1:0] den;
  logic [DCW-1:0]  dcnt;
  logic            neg;

  logic           wr_en;
  logic           is_last;
  logic [AW-1:0]  start_ptr;
  logic [AW-1:0]  back_ptr;
  logic [AW-1:0]  step_ptr;
  logic [DENW:0]  rs;
  logic [SUMW-1:0] mag;
  logic [ELEV_W-1:0] q24;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_V) s = s - DEPTH_V;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + DEPTH_V - {1'b0, b};
    return s[AW-1:0];
  endfunction

  always_comb begin
    int ir, ic, ira, ra, ca;
    ir  = 32'(reg_radius);
    ic  = 32'(reg_cols);
    ira = 32'(reg_rows);
    if (ir == 0) ra = 1; else if (ir > MAX_RADIUS) ra = MAX_RADIUS; else ra = ir;
    if (ic == 0) ca = 1; else if (ic > MAX_COLS) ca = MAX_COLS; else ca = ic;
    if (ira == 0) ir = 1; else if (ira > MAX_ROWS) ir = MAX_ROWS; else ir = ira;
    rad  = RDW'(ra);
    cols = CW'(ca);
    rows = RWW'(ir);
  end

  always_comb begin
    int r, c, rd, lim;
    r  = 32'(nxt_row);
    c  = 32'(nxt_col);
    rd = 32'(rad);
    w_r0 = (r > rd) ? RWW'(r - rd) : '0;
    w_c0 = (c > rd) ? CW'(c - rd) : '0;
    lim = 32'(rows) - 1;
    w_r1 = (r + rd > lim) ? RWW'(lim) : RWW'(r + rd);
    lim = 32'(cols) - 1;
    w_c1 = (c + rd > lim) ? CW'(lim) : CW'(c + rd);
  end

  assign start_ptr = slot_sub(nxt_slot, AW'(nxt_col - w_c0));
  assign back_ptr  = slot_sub(ptr, AW'(cols));
  assign step_ptr  = (sj == wc_hi) ? slot_add(ptr, AW'(cols - span)) : slot_add(ptr, AW'(1));
  assign wr_en     = cmd.take && !kind && !complete;
  assign is_last   = (nxt_row == rows - RWW'(1)) && (nxt_col == cols - CW'(1));

  assign sts.ready     = complete || (in_row > w_r1) || ((in_row == w_r1) && (in_col > w_c1));
  assign sts.back_done = (back_cnt == '0);
  assign sts.scan_last = (si == wr_hi) && (sj == wc_hi);
  assign sts.div_done  = (dcnt == '0);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.last      = is_last;
  assign sts.complete  = complete;

  assign rs  = {rem[DENW-1:0], num[NUMW-1]};
  assign mag = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign q24 = quo[ELEV_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[in_slot] <= elevation;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_radius <= RADIUS_RESET;
      reg_cols   <= DIM_RESET;
      reg_rows   <= DIM_RESET;
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      complete   <= 1'b0;
      nxt_row    <= '0;
      nxt_col    <= '0;
      nxt_slot   <= '0;
      rv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rv <= cmd.scan;
      if (cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_GRID_COLS ||
                     cfg_index == REG_GRID_ROWS)) begin
        unique case (cfg_index)
          REG_RADIUS:    reg_radius <= cfg_data[RAD_REG_W-1:0];
          REG_GRID_COLS: reg_cols   <= cfg_data[DIM_REG_W-1:0];
          default:       reg_rows   <= cfg_data[DIM_REG_W-1:0];
        endcase
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        complete <= 1'b0;
        nxt_row  <= '0;
        nxt_col  <= '0;
        nxt_slot <= '0;
      end else begin
        if (wr_en) begin
          in_slot <= slot_add(in_slot, AW'(1));
          if (in_col == cols - CW'(1)) begin
            in_col <= '0;
            if (in_row == rows - RWW'(1)) begin
              in_row   <= '0;
              complete <= 1'b1;
            end else begin
              in_row <= in_row + RWW'(1);
            end
          end else begin
            in_col <= in_col + CW'(1);
          end
        end
        if (cmd.emit) begin
          if (is_last) begin
            in_row   <= '0;
            in_col   <= '0;
            in_slot  <= '0;
            complete <= 1'b0;
            nxt_row  <= '0;
            nxt_col  <= '0;
            nxt_slot <= '0;
          end else begin
            nxt_slot <= slot_add(nxt_slot, AW'(1));
            if (nxt_col == cols - CW'(1)) begin
              nxt_col <= '0;
              nxt_row <= nxt_row + RWW'(1);
            end else begin
              nxt_col <= nxt_col + CW'(1);
            end
          end
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr      <= start_ptr;
      back_cnt <= RDW'(nxt_row - w_r0);
      si       <= w_r0;
      wr_hi    <= w_r1;
      sj       <= w_c0;
      wc_lo    <= w_c0;
      wc_hi    <= w_c1;
      span     <= w_c1 - w_c0;
      sum      <= '0;
      cnt      <= '0;
    end else begin
      if (cmd.back_row) begin
        ptr      <= back_ptr;
        back_cnt <= back_cnt - RDW'(1);
      end
      if (cmd.scan) begin
        ptr <= step_ptr;
        cnt <= cnt + CNTW'(1);
        if (sj == wc_hi) begin
          sj <= wc_lo;
          si <= si + RWW'(1);
        end else begin
          sj <= sj + CW'(1);
        end
      end
      if (rv) sum <= sum + SUMW'(rd_data);
    end
    if (cmd.div_init) begin
      neg  <= sum[SUMW-1];
      num  <= {mag, 1'b0} + NUMW'(cnt);
      den  <= {cnt, 1'b0};
      rem  <= '0;
      quo  <= '0;
      dcnt <= DCW'(NUMW);
    end else if (cmd.div_step) begin
      num  <= {num[NUMW-2:0], 1'b0};
      dcnt <= dcnt - DCW'(1);
      if (rs >= {1'b0, den}) begin
        rem <= rs - {1'b0, den};
        quo <= {quo[NUMW-2:0], 1'b1};
      end else begin
        rem <= rs;
        quo <= {quo[NUMW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      smoothed     <= neg ? -$signed(q24) : $signed(q24);
      out_row      <= POS_W'(nxt_row);
      out_col      <= POS_W'(nxt_col);
      last_of_grid <= is_last;
    end
  end
endmodule

[rtl/edge_clamped_box_mean_2d.sv]
// Top level of the clamped-edge 2D box mean block.
//   channel  | dir | beat
//   in_ch    | in  | kind, elevation (cell or drain)
//   out_ch   | out | smoothed, out_row, out_col, last_of_grid
//   cfg_*    | in  | register write: radius, grid_cols, grid_rows
// One item at a time. A cell or drain with no result ready ends at the check.
// With a result: one row-store read per window cell in the scan, then a divider
// that makes one bit per cycle; the result waits for a free output register.
// A finished result sits in the output register while the next beat is taken.
// Reset is synchronous; the row store is not cleared.
`timescale 1ns / 1ps
module edge_clamped_box_mean_2d #(
  parameter int MAX_COLS   = ecbm_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = ecbm_pkg::DEF_MAX_ROWS,
  parameter int MAX_RADIUS = ecbm_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk,
  input  logic                            rst,
  ecbm_in_if.sink                         in_ch,
  ecbm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ecbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecbm_pkg::CFG_W-1:0]      cfg_data
);
  import ecbm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  ecbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ecbm_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (in_ch.kind),
    .elevation    (in_ch.elevation),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .smoothed     (out_ch.smoothed),
    .out_row      (out_ch.out_row),
    .out_col      (out_ch.out_col),
    .last_of_grid (out_ch.last_of_grid)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken twice in a row");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_ch.valid && (out_ch.last_of_grid == $past(sts.last)))
    else $error("result register not loaded");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index == REG_RADIUS |=> !sts.complete)
    else $error("register write did not restart grid");
endmodule
